[design/u2mr_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to MacRoman transcoder package
// Shared types, constants and the MacRoman upper-half code point table.
// ----------------------------------------------------------------------------
package u2mr_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned CP_W            = 21;
    localparam logic [7:0]  QMARK           = 8'h3F;

    typedef struct packed {
        logic [2:0]      q_count;
        logic            has_cp;
        logic [CP_W-1:0] cp;
        logic            last;
    } u2mr_entry_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] index;
    } u2mr_hit_t;

    localparam logic [15:0] MAC_HIGH [0:127] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    // Table entries are distinct, so the matching indexes can simply be ORed.
    function automatic u2mr_hit_t mac_lookup(input logic [CP_W-1:0] cp);
        u2mr_hit_t res;
        res = '0;
        for (int k = 0; k < 128; k++)
        begin
            if (cp[CP_W-1:16] == '0 && cp[15:0] == MAC_HIGH[k])
            begin
                res.hit   = 1'b1;
                res.index = res.index | 7'(k);
            end
        end
        return res;
    endfunction

endpackage

[design/u2mr_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 to MacRoman transcoder front end
// Accepts UTF-8 bytes, tracks the open sequence and classifies each byte into
// a queue entry: a number of leading replacements and an optional code point.
// ----------------------------------------------------------------------------
module u2mr_front import u2mr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        push,
    output logic        full,
    input  logic        q_full,
    output logic        q_wr,
    output u2mr_entry_t q_data
);

    logic [CP_W-1:0] pcp_reg, pcp_next;
    logic [1:0]      needed_reg, needed_next;
    logic [1:0]      taken_reg, taken_next;
    logic            accept;
    logic            is_cont;
    logic [CP_W-1:0] cp_acc;
    logic [2:0]      q_cnt;
    logic            has_cp;
    logic [CP_W-1:0] cp;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign is_cont = (in_byte[7:6] == 2'b10);
    assign cp_acc  = {pcp_reg[CP_W-7:0], in_byte[5:0]};

    always_comb
    begin
        pcp_next    = pcp_reg;
        needed_next = needed_reg;
        taken_next  = taken_reg;
        q_cnt       = 3'd0;
        has_cp      = 1'b0;
        cp          = '0;
        if (needed_reg != 2'd0 && is_cont)
        begin
            needed_next = needed_reg - 2'd1;
            if (needed_reg == 2'd1)
            begin
                has_cp     = 1'b1;
                cp         = cp_acc;
                pcp_next   = '0;
                taken_next = 2'd0;
            end
            else
            begin
                pcp_next   = cp_acc;
                taken_next = taken_reg + 2'd1;
            end
        end
        else
        begin
            if (needed_reg != 2'd0)
            begin
                q_cnt = {1'b0, taken_reg};
            end
            pcp_next    = '0;
            needed_next = 2'd0;
            taken_next  = 2'd0;
            if (!in_byte[7])
            begin
                has_cp = 1'b1;
                cp     = {{(CP_W-8){1'b0}}, in_byte};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                pcp_next    = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                needed_next = 2'd1;
                taken_next  = 2'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                pcp_next    = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                needed_next = 2'd2;
                taken_next  = 2'd1;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                pcp_next    = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                needed_next = 2'd3;
                taken_next  = 2'd1;
            end
            else
            begin
                q_cnt = q_cnt + 3'd1;
            end
        end
        if (in_last)
        begin
            if (needed_next != 2'd0)
            begin
                q_cnt = q_cnt + {1'b0, taken_next};
            end
            pcp_next    = '0;
            needed_next = 2'd0;
            taken_next  = 2'd0;
        end
    end

    assign q_wr           = accept && (q_cnt != 3'd0 || has_cp);
    assign q_data.q_count = q_cnt;
    assign q_data.has_cp  = has_cp;
    assign q_data.cp      = cp;
    assign q_data.last    = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcp_reg    <= '0;
            needed_reg <= 2'd0;
            taken_reg  <= 2'd0;
        end
        else if (accept)
        begin
            pcp_reg    <= pcp_next;
            needed_reg <= needed_next;
            taken_reg  <= taken_next;
        end
    end

endmodule

[design/u2mr_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 to MacRoman transcoder entry queue
// Small first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module u2mr_queue import u2mr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  u2mr_entry_t wr_data,
    output logic        q_full,
    output logic        rd_valid,
    input  logic        rd_en,
    output u2mr_entry_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u2mr_entry_t     store_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full   = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[design/u2mr_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 to MacRoman transcoder back end
// Expands each queue entry into output words, maps code points onto MacRoman
// and keeps the per-string clean flag.
// ----------------------------------------------------------------------------
module u2mr_back import u2mr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  u2mr_entry_t head,
    output logic        head_pop,
    output logic [7:0]  out_byte,
    output logic        replaced,
    output logic        out_last,
    output logic        all_clean,
    output logic        empty,
    input  logic        pop
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       repl_reg;
    logic       last_reg;
    logic       clean_out_reg;
    logic       clean_reg;
    logic       load;
    logic [2:0] total;
    logic       final_word;
    u2mr_hit_t  hit;
    logic [7:0] w_byte;
    logic       w_repl;
    logic       w_last;

    assign total      = head.q_count + {2'b00, head.has_cp};
    assign final_word = ((idx_reg + 3'd1) == total);
    assign load       = head_valid && (!valid_reg || pop);
    assign head_pop   = load && final_word;
    assign idx_next   = final_word ? 3'd0 : idx_reg + 3'd1;
    assign hit        = mac_lookup(head.cp);
    assign w_last     = head.last && final_word;

    always_comb
    begin
        w_byte = QMARK;
        w_repl = 1'b1;
        if (idx_reg >= head.q_count)
        begin
            if (head.cp[CP_W-1:7] == '0)
            begin
                w_byte = head.cp[7:0];
                w_repl = 1'b0;
            end
            else if (hit.hit)
            begin
                w_byte = {1'b1, hit.index};
                w_repl = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            idx_reg       <= 3'd0;
            clean_reg     <= 1'b1;
            byte_reg      <= 8'd0;
            repl_reg      <= 1'b0;
            last_reg      <= 1'b0;
            clean_out_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg     <= 1'b1;
                idx_reg       <= idx_next;
                byte_reg      <= w_byte;
                repl_reg      <= w_repl;
                last_reg      <= w_last;
                clean_out_reg <= w_last && clean_reg && !w_repl;
                clean_reg     <= w_last ? 1'b1 : (clean_reg && !w_repl);
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign empty     = !valid_reg;
    assign out_byte  = byte_reg;
    assign replaced  = repl_reg;
    assign out_last  = last_reg;
    assign all_clean = clean_out_reg;

    a_clean_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        all_clean |-> (out_last && !replaced))
        else $error("clean flag set on a word that is not a clean final word");

    a_repl_is_qmark: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && replaced) |-> (out_byte == QMARK))
        else $error("replacement word is not a question mark");

    a_idx_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> (head_valid && idx_reg < total))
        else $error("entry expansion lost its queue head");

    a_dirty_string: assert property (@(posedge clk) disable iff (!rst_n)
        (load && w_repl && !w_last) |=> !clean_reg)
        else $error("replacement did not clear the string clean flag");

endmodule

[design/utf8_to_mac_roman_transcoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 to MacRoman transcoder
// Converts a UTF-8 byte stream, marked on its last byte, into MacRoman words.
//
//   Channel  Handshake        Payload
//   input    push / full      in_byte, in_last
//   result   empty / pop      out_byte, replaced, out_last, all_clean
//
// The front end takes one byte per cycle while the entry queue has room.
// The back end emits one word per cycle while the result is popped; a byte can
// yield up to four words, and the queue absorbs such bursts.
// The first word of a byte is written into the entry queue when the byte is
// accepted and then loaded into the output register, from which it is popped.
// Reset clears the open sequence, the queue and the output, and sets the clean flag.
// ----------------------------------------------------------------------------
module utf8_to_mac_roman_transcoder import u2mr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_byte,
    output logic       replaced,
    output logic       out_last,
    output logic       all_clean,
    output logic       empty,
    input  logic       pop
);

    logic        q_full;
    logic        q_wr;
    u2mr_entry_t q_wdata;
    logic        q_valid;
    logic        q_rd;
    u2mr_entry_t q_rdata;

    u2mr_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push),
        .full    (full),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_data  (q_wdata)
    );

    u2mr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (q_wdata),
        .q_full   (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_rd),
        .rd_data  (q_rdata)
    );

    u2mr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_rdata),
        .head_pop   (q_rd),
        .out_byte   (out_byte),
        .replaced   (replaced),
        .out_last   (out_last),
        .all_clean  (all_clean),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
